// ----- design/cgil_pkg.sv -----
package cgil_pkg;

   localparam int MAX_GRID_DIM_DEF = 64;

   localparam int LOG_FRAC = 16;
   localparam int LOG_W    = 21;
   localparam int LOG_LAT  = LOG_FRAC + 1;

   localparam int INDEX_W = 18;

   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_TILES_ACROSS  = 3'd2;
   localparam logic [2:0] CSR_TILES_DOWN    = 3'd3;
   localparam logic [2:0] CSR_DEPTH_SLICES  = 3'd4;
   localparam logic [2:0] CSR_NEAR_DEPTH    = 3'd5;
   localparam logic [2:0] CSR_FAR_DEPTH     = 3'd6;
   localparam logic [2:0] CSR_SLICE_MODE    = 3'd7;

   localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1920;
   localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd1080;
   localparam logic [6:0]  RST_TILES_ACROSS  = 7'd16;
   localparam logic [6:0]  RST_TILES_DOWN    = 7'd9;
   localparam logic [6:0]  RST_DEPTH_SLICES  = 7'd24;
   localparam logic [31:0] RST_NEAR_DEPTH    = 32'd6554;
   localparam logic [31:0] RST_FAR_DEPTH     = 32'd65536000;
   localparam logic        RST_SLICE_MODE    = 1'b1;

   typedef struct packed {
      logic below;
      logic beyond;
      logic flat;
   } slice_flags_type;

endpackage

// ----- design/cgil_delay.sv -----
module cgil_delay
   import cgil_pkg::*;
#(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] sh_ff [0:N-1];

   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff[0] <= din;
         for (int i = 1; i < N; i++) begin
            sh_ff[i] <= sh_ff[i-1];
         end
      end
   end

   assign dout = sh_ff[N-1];

endmodule

// ----- design/cgil_log2.sv -----
module cgil_log2
   import cgil_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [31:0]      value,
   output logic [LOG_W-1:0] log_q
);

   logic [31:0]         m_ff  [0:LOG_FRAC];
   logic [LOG_FRAC-1:0] fr_ff [0:LOG_FRAC];
   logic [4:0]          p_ff  [0:LOG_FRAC];
   logic                z_ff  [0:LOG_FRAC];

   logic [4:0]  lead;
   logic [31:0] norm;

   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (value[i]) lead = 5'(i);
      end
      norm = value << (5'd31 - lead);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]  <= norm;
         fr_ff[0] <= '0;
         p_ff[0]  <= lead;
         z_ff[0]  <= (value == 32'd0);
      end
   end

   for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
      logic [63:0]         sq;
      logic [32:0]         m2;
      logic [31:0]         m_in;
      logic [LOG_FRAC-1:0] fr_in;

      always_comb begin
         sq    = 64'(m_ff[k-1]) * 64'(m_ff[k-1]);
         m2    = sq[63:31];
         m_in  = m2[32] ? m2[32:1] : m2[31:0];
         fr_in = {fr_ff[k-1][LOG_FRAC-2:0], m2[32]};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[k]  <= m_in;
            fr_ff[k] <= fr_in;
            p_ff[k]  <= p_ff[k-1];
            z_ff[k]  <= z_ff[k-1];
         end
      end
   end

   assign log_q = z_ff[LOG_FRAC] ? '0 : {p_ff[LOG_FRAC], fr_ff[LOG_FRAC]};

endmodule

// ----- design/cgil_div.sv -----
module cgil_div
   import cgil_pkg::*;
#(
   parameter int NW = 39,
   parameter int DW = 32,
   parameter int QB = 7
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QB-1:0] quot,
   output logic          over
);

   localparam int W = (NW > DW + QB) ? NW : DW + QB;

   logic [W-1:0]  rem_ff [0:QB];
   logic [DW-1:0] d_ff   [0:QB];
   logic [QB-1:0] q_ff   [0:QB];
   logic          ov_ff  [0:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= W'(num);
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         ov_ff[0]  <= (W'(num) >= (W'(den) << QB));
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_bit
      logic [W-1:0]  sh;
      logic [W-1:0]  rem_in;
      logic [QB-1:0] q_in;

      always_comb begin
         sh     = W'(d_ff[k-1]) << (QB - k);
         rem_in = rem_ff[k-1];
         q_in   = q_ff[k-1];
         if (rem_ff[k-1] >= sh) begin
            rem_in       = rem_ff[k-1] - sh;
            q_in[QB - k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            d_ff[k]   <= d_ff[k-1];
            q_ff[k]   <= q_in;
            ov_ff[k]  <= ov_ff[k-1];
         end
      end
   end

   assign quot = q_ff[QB];
   assign over = ov_ff[QB];

endmodule

// ----- design/cluster_grid_index_lookup_unit.sv -----
// path from req item to rsp item: the log2 units, stage a, stage b, the dividers, stage c and stage d;
// the log2 units end in a 16-stage squaring chain and the dividers are bit-per-stage
// throughput: one item per cycle; the whole pipeline advances together and holds
// while an rsp item waits
// reset: synchronous, clears the valid bits and loads the register defaults
module cluster_grid_index_lookup_unit
   import cgil_pkg::*;
#(
   parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pos_x, pos_y, depth
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // cluster_number, zero pad
   output logic [0:0]  rsp_tuser,   // outside_grid
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int DIMW = $clog2(MAX_GRID_DIM + 1);
   localparam int TOT  = LOG_LAT + 5 + DIMW;
   localparam int ZNW  = 32 + DIMW;
   localparam int TNW  = 16 + DIMW;
   localparam int SW   = (3 * DIMW + 2 > INDEX_W) ? 3 * DIMW + 2 : INDEX_W;

   logic [11:0] sw_ff, sh_ff;
   logic [6:0]  ta_ff, td_ff, ds_ff;
   logic [31:0] near_ff, far_ff;
   logic        mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff   <= RST_SCREEN_WIDTH;
         sh_ff   <= RST_SCREEN_HEIGHT;
         ta_ff   <= RST_TILES_ACROSS;
         td_ff   <= RST_TILES_DOWN;
         ds_ff   <= RST_DEPTH_SLICES;
         near_ff <= RST_NEAR_DEPTH;
         far_ff  <= RST_FAR_DEPTH;
         mode_ff <= RST_SLICE_MODE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  sw_ff   <= csr_wdata[11:0];
            CSR_SCREEN_HEIGHT: sh_ff   <= csr_wdata[11:0];
            CSR_TILES_ACROSS:  ta_ff   <= csr_wdata[6:0];
            CSR_TILES_DOWN:    td_ff   <= csr_wdata[6:0];
            CSR_DEPTH_SLICES:  ds_ff   <= csr_wdata[6:0];
            CSR_NEAR_DEPTH:    near_ff <= csr_wdata;
            CSR_FAR_DEPTH:     far_ff  <= csr_wdata;
            CSR_SLICE_MODE:    mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   function automatic logic [DIMW-1:0] eff_dim(input logic [6:0] v);
      if (v == 7'd0) return DIMW'(1);
      if (32'(v) > 32'(MAX_GRID_DIM)) return DIMW'(MAX_GRID_DIM);
      return DIMW'(v);
   endfunction

   logic [DIMW-1:0] dx, dy, dz;
   logic [15:0]     wdiv, hdiv;

   always_comb begin
      dx   = eff_dim(ta_ff);
      dy   = eff_dim(td_ff);
      dz   = eff_dim(ds_ff);
      wdiv = {(sw_ff == 12'd0) ? 12'd1 : sw_ff, 4'd0};
      hdiv = {(sh_ff == 12'd0) ? 12'd1 : sh_ff, 4'd0};
   end

   // valid bits and global advance
   logic v_ff [0:TOT-1];
   logic en;

   assign en         = !v_ff[TOT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[TOT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOT; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int i = 1; i < TOT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   // log2 of depth, near and far in lockstep
   logic [LOG_W-1:0] l_d, l_n, l_f;
   logic [63:0]      item_dly;

   cgil_log2 u_log_d (.clock, .en, .value(req_tdata[63:32]), .log_q(l_d));
   cgil_log2 u_log_n (.clock, .en, .value(near_ff), .log_q(l_n));
   cgil_log2 u_log_f (.clock, .en, .value(far_ff), .log_q(l_f));

   cgil_delay #(.W(64), .N(LOG_LAT)) u_item_dly (
      .clock, .en, .din(req_tdata), .dout(item_dly)
   );

   // stage a: slice numerator, denominator and special cases
   logic [15:0]     px_a_ff, py_a_ff;
   logic [31:0]     num_a_ff, den_a_ff;
   slice_flags_type fl_a_ff, fl_a_in;
   logic [LOG_W:0]  lnum, lden;
   logic [31:0]     dval, num_a_in, den_a_in;

   always_comb begin
      dval           = item_dly[63:32];
      lnum           = {1'b0, l_d} - {1'b0, l_n};
      lden           = {1'b0, l_f} - {1'b0, l_n};
      fl_a_in.below  = dval < near_ff;
      fl_a_in.beyond = dval >= far_ff;
      fl_a_in.flat   = mode_ff && (lden[LOG_W] || lden == '0 || lnum[LOG_W]);
      if (mode_ff) begin
         num_a_in = 32'(lnum[LOG_W-1:0]);
         den_a_in = 32'(lden[LOG_W-1:0]);
      end else begin
         num_a_in = dval - near_ff;
         den_a_in = far_ff - near_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_a_ff  <= item_dly[15:0];
         py_a_ff  <= item_dly[31:16];
         num_a_ff <= num_a_in;
         den_a_ff <= den_a_in;
         fl_a_ff  <= fl_a_in;
      end
   end

   // stage b: scale by grid dimensions
   logic [ZNW-1:0] zn_b_ff;
   logic [31:0]    zd_b_ff;
   logic [TNW-1:0] xn_b_ff, yn_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         zn_b_ff <= ZNW'(dz) * ZNW'(num_a_ff);
         zd_b_ff <= den_a_ff;
         xn_b_ff <= TNW'(dx) * TNW'(px_a_ff);
         yn_b_ff <= TNW'(dy) * TNW'(py_a_ff);
      end
   end

   // bit-per-stage dividers
   logic [DIMW-1:0] qz, qx, qy;
   logic            oz, ox, oy;
   slice_flags_type fl_d;

   cgil_div #(.NW(ZNW), .DW(32), .QB(DIMW)) u_div_z (
      .clock, .en, .num(zn_b_ff), .den(zd_b_ff), .quot(qz), .over(oz)
   );
   cgil_div #(.NW(TNW), .DW(16), .QB(DIMW)) u_div_x (
      .clock, .en, .num(xn_b_ff), .den(wdiv), .quot(qx), .over(ox)
   );
   cgil_div #(.NW(TNW), .DW(16), .QB(DIMW)) u_div_y (
      .clock, .en, .num(yn_b_ff), .den(hdiv), .quot(qy), .over(oy)
   );

   cgil_delay #(.W($bits(slice_flags_type)), .N(DIMW + 2)) u_flag_dly (
      .clock, .en, .din(fl_a_ff), .dout(fl_d)
   );

   // stage c: clamp slice, grid check, partial products
   logic [DIMW-1:0]   tx_c_ff, tz_c_ff, tz_c_in;
   logic [2*DIMW-1:0] tydx_c_ff, dxdy_c_ff;
   logic              out_c_ff;

   always_comb begin
      if (fl_d.below) begin
         tz_c_in = '0;
      end else if (fl_d.beyond) begin
         tz_c_in = dz - DIMW'(1);
      end else if (fl_d.flat) begin
         tz_c_in = '0;
      end else if (oz || qz >= dz) begin
         tz_c_in = dz - DIMW'(1);
      end else begin
         tz_c_in = qz;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_c_ff   <= qx;
         tz_c_ff   <= tz_c_in;
         tydx_c_ff <= (2*DIMW)'(qy) * (2*DIMW)'(dx);
         dxdy_c_ff <= (2*DIMW)'(dx) * (2*DIMW)'(dy);
         out_c_ff  <= ox || oy || qx >= dx || qy >= dy;
      end
   end

   // stage d: linear index into the output register
   logic [SW-1:0]      idx;
   logic [INDEX_W-1:0] num_d_ff;
   logic               out_d_ff;

   assign idx = SW'(tx_c_ff) + SW'(tydx_c_ff) + SW'(tz_c_ff) * SW'(dxdy_c_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         num_d_ff <= out_c_ff ? '0 : idx[INDEX_W-1:0];
         out_d_ff <= out_c_ff;
      end
   end

   assign rsp_tdata = {6'd0, num_d_ff};
   assign rsp_tuser = out_d_ff;

endmodule

// ----- tb/tb_cluster_grid_index_lookup_unit.sv -----
module tb_cluster_grid_index_lookup_unit;
   import cgil_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [17:0] number;
      logic        outside;
   } cluster_result_type;

   class cluster_scoreboard;
      bit [11:0]          width, height;
      bit [6:0]           across, down, slices;
      bit [31:0]          near_d, far_d;
      bit                 mode;
      cluster_result_type pending[$];
      int                 mismatches;

      function new();
         width = RST_SCREEN_WIDTH;
         height = RST_SCREEN_HEIGHT;
         across = RST_TILES_ACROSS;
         down = RST_TILES_DOWN;
         slices = RST_DEPTH_SLICES;
         near_d = RST_NEAR_DEPTH;
         far_d = RST_FAR_DEPTH;
         mode = RST_SLICE_MODE;
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_SCREEN_WIDTH:  width = v[11:0];
            CSR_SCREEN_HEIGHT: height = v[11:0];
            CSR_TILES_ACROSS:  across = v[6:0];
            CSR_TILES_DOWN:    down = v[6:0];
            CSR_DEPTH_SLICES:  slices = v[6:0];
            CSR_NEAR_DEPTH:    near_d = v;
            CSR_FAR_DEPTH:     far_d = v;
            CSR_SLICE_MODE:    mode = v[0];
            default: ;
         endcase
      endfunction

      function longint unsigned grid_dim(bit [6:0] v);
         if (v == 0) return 1;
         if (v > MAX_GRID_DIM_DEF) return MAX_GRID_DIM_DEF;
         return v;
      endfunction

      // leading one plus 16 fraction bits by repeated squaring
      function longint log2_fixed(bit [31:0] v);
         int p;
         longint unsigned m;
         longint frac;
         p = 31;
         frac = 0;
         if (v == 0) return 0;
         while (!v[p]) p--;
         m = (64'(v) << (31 - p)) & 64'hFFFF_FFFF;
         for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
               frac = frac | 1;
               m = m >> 1;
            end
         end
         return longint'(p) * 65536 + frac;
      endfunction

      function longint unsigned slice_index(bit [31:0] d, longint unsigned dz);
         longint unsigned s;
         longint ln, num, den;
         if (d < near_d) return 0;
         if (d >= far_d) return dz - 1;
         if (mode == 1'b0) begin
            s = (dz * 64'(d - near_d)) / 64'(far_d - near_d);
         end else begin
            ln = log2_fixed(near_d);
            num = log2_fixed(d) - ln;
            den = log2_fixed(far_d) - ln;
            if (den <= 0 || num < 0) return 0;
            s = (dz * longint'(num)) / longint'(den);
         end
         return (s >= dz) ? dz - 1 : s;
      endfunction

      function void note_item(bit [15:0] px, bit [15:0] py, bit [31:0] d);
         longint unsigned dx, dy, dz, tx, ty, tz, w, h;
         cluster_result_type r;
         dx = grid_dim(across);
         dy = grid_dim(down);
         dz = grid_dim(slices);
         w = (width == 0) ? 1 : width;
         h = (height == 0) ? 1 : height;
         tx = (64'(px) * dx) / (16 * w);
         ty = (64'(py) * dy) / (16 * h);
         tz = slice_index(d, dz);
         if (tx >= dx || ty >= dy) begin
            r.number = '0;
            r.outside = 1'b1;
         end else begin
            r.number = 18'(tx + ty * dx + tz * dx * dy);
            r.outside = 1'b0;
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [17:0] number, logic outside);
         cluster_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: number %0d outside %0b", number, outside);
            return;
         end
         e = pending.pop_front();
         if (number !== e.number || outside !== e.outside) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected number %0d outside %0b, got number %0d outside %0b",
                        e.number, e.outside, number, outside);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   cluster_scoreboard sb;
   int burst_left;
   int stall_mode = 0;
   int stall_count = 0;

   cluster_grid_index_lookup_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: stall pattern is redrawn periodically at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[17:0], rsp_tuser[0]);
      stall_count <= stall_count + 1;
      if (stall_count % 300 == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= (stall_count % 7 < 2);
         default: rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_item(bit [15:0] px, bit [15:0] py, bit [31:0] d);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {d, py, px};
      do @(posedge clock); while (!req_tready);
      sb.note_item(px, py, d);
   endtask

   task automatic set_grid(int w, int h, int ax, int dn, int sl, bit [31:0] n,
                           bit [31:0] f, bit m);
      req_tvalid <= 1'b0;
      @(posedge clock);
      drain();
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, h);
      write_csr(CSR_TILES_ACROSS, ax);
      write_csr(CSR_TILES_DOWN, dn);
      write_csr(CSR_DEPTH_SLICES, sl);
      write_csr(CSR_NEAR_DEPTH, n);
      write_csr(CSR_FAR_DEPTH, f);
      write_csr(CSR_SLICE_MODE, 32'(m));
      csr_we <= 1'b0;
   endtask

   function automatic bit [31:0] pick_depth();
      bit [31:0] n, f;
      n = sb.near_d;
      f = sb.far_d;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom >> $urandom_range(0, 31);
         2: begin
            case ($urandom_range(0, 3))
               0: return n - 1;
               1: return n;
               2: return f - 1;
               default: return f;
            endcase
         end
         default: begin
            if (f > n) return n + $urandom_range(0, f - n - 1);
            return $urandom;
         end
      endcase
   endfunction

   function automatic bit [15:0] pick_pos(int size);
      int lim;
      lim = 16 * ((size == 0) ? 1 : size) + 40;
      if (lim > 65535) lim = 65535;
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, lim);
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++)
         send_item(pick_pos(sb.width), pick_pos(sb.height), pick_depth());
   endtask

   initial begin
      bit [31:0] n, f;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings
      send_item(16'h0000, 16'h0000, 32'h0);
      send_item(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(16'd30719, 16'd17279, 32'd6553);
      send_item(16'd30720, 16'd100, 32'd6554);
      send_item(16'd100, 16'd17280, 32'd65535999);
      send_item(16'd15000, 16'd8000, 32'd65536000);
      send_item(16'd1, 16'd1, 32'h0001_0000);
      send_item(16'hAAAA, 16'h5555, 32'hAAAA_5555);
      send_item(16'h5555, 16'h2AAA, 32'h5555_AAAA);

      // extremes, linear
      set_grid(4095, 4095, 64, 64, 64, 32'd1, 32'hFFFF_FFFF, 1'b0);
      send_item(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFE);
      send_item(16'hFFEF, 16'hFFEF, 32'h8000_0000);
      send_item(16'h0000, 16'hFFFF, 32'h0);
      send_item(16'h1234, 16'h4321, 32'd1);
      random_items(60);

      // zero sizes, near at zero, exponential
      set_grid(0, 0, 0, 0, 0, 32'd0, 32'd1000, 1'b1);
      send_item(16'd0, 16'd0, 32'd0);
      send_item(16'd15, 16'd15, 32'd500);
      send_item(16'd16, 16'd0, 32'd999);
      random_items(30);

      // oversized counts, near not below far
      set_grid(640, 480, 127, 100, 127, 32'd5000, 32'd100, 1'b1);
      send_item(16'd200, 16'd300, 32'd99);
      send_item(16'd200, 16'd300, 32'd4999);
      send_item(16'd200, 16'd300, 32'd5000);
      random_items(40);

      // flat log range
      set_grid(320, 200, 8, 8, 16, 32'h0001_0000, 32'h0001_0001, 1'b1);
      send_item(16'd100, 16'd100, 32'h0001_0000);
      random_items(20);

      for (int ph = 0; ph < 8; ph++) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >> $urandom_range(8, 31));
         f = n + 1 + ($urandom >> $urandom_range(0, 31));
         if (f <= n) f = 32'hFFFF_FFFF;
         set_grid($urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 4095),
                  $urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 4095),
                  $urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                  n, f, $urandom_range(0, 1));
         random_items(50);
         if (ph == 3) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending.size() != 0) @(posedge clock);
         end
         random_items(50);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
